// ----- design/mhse_pkg.sv -----
package mhse_pkg;

  localparam int KeyW      = 31;
  localparam int CountW    = 7;
  localparam int BucketW   = 6;
  localparam int DefBuckets = 64;
  localparam int DefWays    = 4;
  localparam logic [CountW-1:0] CountReset = 7'd64;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_MODIFY
  } state_e;

  typedef struct packed {
    kind_e            kind;
    logic [KeyW-1:0]  key;
  } item_t;

  typedef struct packed {
    logic                found;
    status_e             status;
    logic [BucketW-1:0]  bucket;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
  } slot_t;

endpackage

// ----- design/modulo_hash_set_engine_core.sv -----
// Hash set of 31-bit keys in a row memory of BUCKETS rows by WAYS slots. A key's bucket
// is the key modulo the bucket count register (zero read as one, clamped to the row
// count), taken by a restoring divider one key bit per cycle. Insert, delete and search
// each go from start to the done strobe through the accept, the divider, the memory
// read and the row update and write back. Clear rewrites every row, one row per cycle,
// and gives its done strobe with the last row. After reset the same clearing pass runs
// with busy high and no result. busy is high from accept to the done strobe;
// each result is shown for one cycle with done_o and must be taken then. The bucket
// count register may be written only while busy is low.
module modulo_hash_set_engine_core #(
  parameter int BUCKETS = mhse_pkg::DefBuckets,
  parameter int WAYS    = mhse_pkg::DefWays
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  mhse_pkg::item_t                 in_i,
  input  logic                            cfg_we_i,
  input  logic [mhse_pkg::CountW-1:0]     cfg_wdata_i,
  output logic                            done_o,
  output mhse_pkg::result_t               out_o
);

  localparam int RowW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CntW   = $clog2(mhse_pkg::KeyW);
  localparam int CapInt = (BUCKETS < 127) ? BUCKETS : 127;
  localparam logic [mhse_pkg::CountW-1:0] Cap = mhse_pkg::CountW'(CapInt);
  localparam logic [RowW-1:0] LastRow = RowW'(BUCKETS - 1);
  localparam logic [CntW-1:0] LastBit = CntW'(mhse_pkg::KeyW - 1);

  typedef mhse_pkg::slot_t [WAYS-1:0] row_t;

  mhse_pkg::state_e state_q, state_d;
  logic [mhse_pkg::CountW-1:0] count_q;
  logic [mhse_pkg::CountW-1:0] divisor;
  mhse_pkg::kind_e kind_q, kind_d;
  logic [mhse_pkg::KeyW-1:0] key_q, key_d;
  logic [mhse_pkg::CountW-1:0] rem_q, rem_d;
  logic [CntW-1:0] bit_q, bit_d;
  logic [RowW-1:0] row_q, row_d;
  logic [RowW-1:0] clr_q, clr_d;
  logic emit_q, emit_d;
  logic done_q, done_d;
  mhse_pkg::result_t res_q, res_d;

  row_t mem [BUCKETS];
  row_t rdata_q;
  logic rd_en;
  logic we;
  logic [RowW-1:0] waddr;
  row_t wdata;

  logic [mhse_pkg::CountW:0] shifted;
  logic [RowW+mhse_pkg::CountW-1:0] rem_wide;
  logic [RowW-1:0] rem_row;

  // effective divisor: zero reads as one, clamped to the row count
  always_comb begin
    divisor = count_q;
    if (divisor == '0) begin
      divisor = mhse_pkg::CountW'(1);
    end else if (divisor > Cap) begin
      divisor = Cap;
    end
  end

  assign shifted  = {rem_q, key_q[bit_q]};
  assign rem_wide = {{RowW{1'b0}}, rem_q};
  assign rem_row  = rem_wide[RowW-1:0];

  // row update for insert, delete and search
  row_t mod_row;
  logic hit;
  logic space;
  always_comb begin
    mod_row = rdata_q;
    hit     = 1'b0;
    space   = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (kind_q == mhse_pkg::KIND_INSERT) begin
        if (!space && !rdata_q[w].valid) begin
          space = 1'b1;
          mod_row[w].valid = 1'b1;
          mod_row[w].key   = key_q;
        end
      end else if (!hit && rdata_q[w].valid && rdata_q[w].key == key_q) begin
        hit = 1'b1;
        if (kind_q == mhse_pkg::KIND_DELETE) begin
          mod_row[w].valid = 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    key_d   = key_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    row_d   = row_q;
    clr_d   = clr_q;
    emit_d  = emit_q;
    done_d  = 1'b0;
    res_d   = res_q;
    rd_en   = 1'b0;
    we      = 1'b0;
    waddr   = row_q;
    wdata   = mod_row;
    case (state_q)
      mhse_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + RowW'(1);
        if (clr_q == LastRow) begin
          state_d = mhse_pkg::ST_IDLE;
          clr_d   = '0;
          if (emit_q) begin
            done_d = 1'b1;
            res_d  = '{found: 1'b0, status: mhse_pkg::STATUS_DONE, bucket: '0};
          end
        end
      end
      mhse_pkg::ST_IDLE: begin
        if (start) begin
          kind_d = in_i.kind;
          key_d  = in_i.key;
          rem_d  = '0;
          bit_d  = LastBit;
          clr_d  = '0;
          emit_d = 1'b1;
          if (in_i.kind == mhse_pkg::KIND_CLEAR) begin
            state_d = mhse_pkg::ST_CLEAR;
          end else begin
            state_d = mhse_pkg::ST_DIV;
          end
        end
      end
      mhse_pkg::ST_DIV: begin
        if (shifted >= {1'b0, divisor}) begin
          rem_d = mhse_pkg::CountW'(shifted - {1'b0, divisor});
        end else begin
          rem_d = shifted[mhse_pkg::CountW-1:0];
        end
        bit_d = bit_q - CntW'(1);
        if (bit_q == '0) begin
          state_d = mhse_pkg::ST_READ;
        end
      end
      mhse_pkg::ST_READ: begin
        rd_en   = 1'b1;
        row_d   = rem_row;
        state_d = mhse_pkg::ST_MODIFY;
      end
      mhse_pkg::ST_MODIFY: begin
        we      = 1'b1;
        done_d  = 1'b1;
        state_d = mhse_pkg::ST_IDLE;
        res_d.bucket = rem_q[mhse_pkg::BucketW-1:0];
        if (kind_q == mhse_pkg::KIND_INSERT) begin
          res_d.found  = 1'b0;
          res_d.status = space ? mhse_pkg::STATUS_DONE : mhse_pkg::STATUS_FULL;
        end else begin
          res_d.found  = hit;
          res_d.status = hit ? mhse_pkg::STATUS_DONE : mhse_pkg::STATUS_ABSENT;
        end
      end
      default: begin
        state_d = mhse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhse_pkg::ST_CLEAR;
      count_q <= mhse_pkg::CountReset;
      bit_q   <= '0;
      clr_q   <= '0;
      emit_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      bit_q   <= bit_d;
      clr_q   <= clr_d;
      emit_q  <= emit_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    key_q  <= key_d;
    rem_q  <= rem_d;
    row_q  <= row_d;
    res_q  <= res_d;
  end

  // row memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rem_row];
    end
  end

  assign busy   = (state_q != mhse_pkg::ST_IDLE);
  assign done_o = done_q;
  assign out_o  = res_q;

endmodule

// ----- test/modulo_hash_set_engine_core_tb.sv -----
module modulo_hash_set_engine_core_tb;
  import mhse_pkg::*;

  localparam int Buckets      = DefBuckets;
  localparam int Ways         = DefWays;
  localparam int Slots        = Buckets * Ways;
  localparam int CycleLimit   = 1500000;
  localparam int DrainCycles  = Buckets + 8;
  localparam int PhaseItems   = 153;
  localparam int PhaseCount   = 10;
  localparam int MaxGap       = 70;

  class hash_set_scoreboard;
    logic [CountW-1:0] count_reg;
    logic [KeyW-1:0]   slot_key [Slots];
    bit                slot_used [Slots];
    result_t           pending_results [$];
    int unsigned       errors;

    function new();
      count_reg = CountReset;
      errors = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (slot_key[i]) slot_key[i] = '0;
    endfunction

    // mirror of one accepted operation on the bucket rows
    function void note_op(item_t it);
      int unsigned n;
      int unsigned row;
      int unsigned base;
      bit          hit;
      result_t     r;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > Buckets) n = Buckets;
      row = it.key % n;
      base = row * Ways;
      hit = 1'b0;
      r.found = 1'b0;
      r.status = STATUS_DONE;
      case (it.kind)
        KIND_INSERT: begin
          r.status = STATUS_FULL;
          for (int w = 0; w < Ways; w++) begin
            if (!hit && !slot_used[base + w]) begin
              slot_key[base + w] = it.key;
              slot_used[base + w] = 1'b1;
              r.status = STATUS_DONE;
              hit = 1'b1;
            end
          end
        end
        KIND_DELETE, KIND_SEARCH: begin
          r.status = STATUS_ABSENT;
          for (int w = 0; w < Ways; w++) begin
            if (!hit && slot_used[base + w] && slot_key[base + w] == it.key) begin
              if (it.kind == KIND_DELETE) slot_used[base + w] = 1'b0;
              r.found = 1'b1;
              r.status = STATUS_DONE;
              hit = 1'b1;
            end
          end
        end
        default: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          row = 0;
        end
      endcase
      r.bucket = row[BucketW-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, actual found %0d status %0d bucket %0d",
                 $time, got.found, got.status, got.bucket);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0d actual %0d", $time, want.found, got.found);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.bucket !== want.bucket) begin
        $display("%0t: bucket mismatch, expected %0d actual %0d",
                 $time, want.bucket, got.bucket);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  item_t             in_i;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;
  logic              done_o;
  result_t           out_o;

  hash_set_scoreboard sb = new();
  int unsigned        cycles = 0;
  int unsigned        idle_pct = 0;
  logic [KeyW-1:0]    key_pool [$];

  modulo_hash_set_engine_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .out_o       (out_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(out_o);
  end

  task automatic send_op(kind_e k, logic [KeyW-1:0] key);
    item_t it;
    it.kind = k;
    it.key = key;
    start <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_op(it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CountW-1:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.count_reg = v;
  endtask

  task automatic random_op();
    int unsigned     r;
    logic [31:0]     raw;
    logic [KeyW-1:0] key;
    kind_e           k;
    r = $urandom_range(0, 99);
    if (r < 3) k = KIND_CLEAR;
    else if (r < 45) k = KIND_INSERT;
    else if (r < 70) k = KIND_DELETE;
    else k = KIND_SEARCH;
    r = $urandom_range(0, 99);
    raw = $urandom;
    // often a recently inserted key so deletes and searches can hit
    if (r < 45 && key_pool.size() != 0) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else if (r < 80) key = KeyW'($urandom_range(0, 300));
    else if (r < 90) key = {KeyW{1'b1}} - KeyW'($urandom_range(0, 300));
    else key = raw[KeyW-1:0];
    if (k == KIND_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
    send_op(k, key);
  endtask

  initial begin
    logic [CountW-1:0] phase_count [PhaseCount];
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    phase_count = '{7'd64, 7'd1, 7'd127, 7'd13, 7'd65, 7'd0, 7'd64, 7'd37, 7'd2, 7'd64};
    phase_count[5] = CountW'($urandom_range(2, 63));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass after reset
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // directed: empty table, zero key, top key, full bucket, duplicates
    send_op(KIND_SEARCH, 31'd0);
    send_op(KIND_DELETE, 31'd0);
    send_op(KIND_INSERT, 31'd0);
    send_op(KIND_SEARCH, 31'd0);
    send_op(KIND_INSERT, 31'h7FFF_FFFF);
    send_op(KIND_SEARCH, 31'h7FFF_FFFF);
    send_op(KIND_DELETE, 31'h7FFF_FFFF);
    send_op(KIND_DELETE, 31'h7FFF_FFFF);
    send_op(KIND_INSERT, 31'd5);
    send_op(KIND_INSERT, 31'd69);
    send_op(KIND_INSERT, 31'd133);
    send_op(KIND_INSERT, 31'd197);
    send_op(KIND_INSERT, 31'd261);
    send_op(KIND_SEARCH, 31'd261);
    send_op(KIND_DELETE, 31'd69);
    send_op(KIND_INSERT, 31'd5);
    send_op(KIND_SEARCH, 31'd133);
    send_op(KIND_CLEAR, 31'h2AAA_AAAA);
    send_op(KIND_SEARCH, 31'd5);
    // zero divisor acts as one bucket
    write_count(7'd0);
    send_op(KIND_INSERT, 31'd7);
    send_op(KIND_INSERT, 31'd9);
    send_op(KIND_SEARCH, 31'd9);
    // oversized divisor clamps, stored keys are not rehashed
    write_count(7'd127);
    send_op(KIND_SEARCH, 31'd9);
    send_op(KIND_SEARCH, 31'd7);

    for (int p = 0; p < PhaseCount; p++) begin
      write_count(phase_count[p]);
      key_pool.delete();
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 73;
        default: idle_pct = 10;
      endcase
      for (int i = 0; i < PhaseItems; i++) random_op();
    end

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mhse_pkg.sv
design/modulo_hash_set_engine_core.sv
test/modulo_hash_set_engine_core_tb.sv
